>>> rtl/alarm_clock_hms_top_defines.svh
// Assertion macros shared by the alarm clock RTL.
`ifndef ALARM_CLOCK_HMS_TOP_DEFINES_SVH
`define ALARM_CLOCK_HMS_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define ACHMS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("alarm clock assertion failed");

// Next-cycle implication, disabled while in reset.
`define ACHMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("alarm clock assertion failed");

`endif

>>> rtl/achms_pkg.sv
// Types, constants and helper functions for the alarm clock.
package achms_pkg;

    localparam logic [6:0] MINUTES_PER_HOUR = 7'd60;
    localparam logic [5:0] HOURS_PER_DAY    = 6'd24;
    localparam logic [6:0] SECS_PER_MIN     = 7'd60;

    typedef enum logic [2:0] {
        ACT_TICK      = 3'd0,
        ACT_MODE      = 3'd1,
        ACT_MINUTE    = 3'd2,
        ACT_HOUR      = 3'd3,
        ACT_LOAD      = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        MODE_CLOCK     = 2'd0,
        MODE_SET_TIME  = 2'd1,
        MODE_SET_ALARM = 2'd2
    } mode_t;

    typedef struct packed {
        action_t    action;
        logic [4:0] load_hours;
        logic [5:0] load_mins;
        logic [5:0] load_secs;
    } item_t;

    typedef struct packed {
        logic [5:0] cur_secs;
        logic [5:0] cur_mins;
        logic [4:0] cur_hours;
        logic       valid_flag;
        mode_t      mode;
        logic [5:0] edit_mins;
        logic [4:0] edit_hours;
        logic [5:0] alarm_mins;
        logic [4:0] alarm_hours;
        logic       armed_flag;
        logic       sound_flag;
    } state_t;

    typedef struct packed {
        logic [4:0] show_hours;
        logic [5:0] show_mins;
        logic [5:0] show_secs;
        logic [1:0] show_mode;
        logic       sound_active;
        logic       alarm_armed;
        logic       time_valid;
    } result_t;

    // Increment with wrap to zero at limit.
    function automatic logic [5:0] bump6(input logic [5:0] v, input logic [6:0] limit);
        logic [6:0] n;
        n = {1'b0, v} + 7'd1;
        return (n >= limit) ? 6'd0 : n[5:0];
    endfunction

    function automatic logic [4:0] bump5(input logic [4:0] v, input logic [5:0] limit);
        logic [5:0] n;
        n = {1'b0, v} + 6'd1;
        return (n >= limit) ? 5'd0 : n[4:0];
    endfunction

    // Out-of-range load values are stored as zero.
    function automatic logic [5:0] fit6(input logic [5:0] v, input logic [6:0] limit);
        return ({1'b0, v} >= limit) ? 6'd0 : v;
    endfunction

    function automatic logic [4:0] fit5(input logic [4:0] v, input logic [5:0] limit);
        return ({1'b0, v} >= limit) ? 5'd0 : v;
    endfunction

endpackage

>>> rtl/achms_req_if.sv
// Request channel: one clock event with its load values.
interface achms_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [4:0] load_hours;
    logic [5:0] load_mins;
    logic [5:0] load_secs;

    modport source (output valid, output action, output load_hours, output load_mins,
                    output load_secs, input ready);
    modport sink   (input valid, input action, input load_hours, input load_mins,
                    input load_secs, output ready);
endinterface

// Response channel: display and flags after one request.
interface achms_rsp_if;
    logic       valid;
    logic       ready;
    logic [4:0] show_hours;
    logic [5:0] show_mins;
    logic [5:0] show_secs;
    logic [1:0] show_mode;
    logic       sound_active;
    logic       alarm_armed;
    logic       time_valid;

    modport source (output valid, output show_hours, output show_mins, output show_secs,
                    output show_mode, output sound_active, output alarm_armed,
                    output time_valid, input ready);
    modport sink   (input valid, input show_hours, input show_mins, input show_secs,
                    input show_mode, input sound_active, input alarm_armed,
                    input time_valid, output ready);
endinterface

>>> rtl/achms_step.sv
// Next-state and display logic for one clock event.
module achms_step (
    input  achms_pkg::item_t   item,
    input  achms_pkg::state_t  state,
    output achms_pkg::state_t  state_next,
    output achms_pkg::result_t result
);

    logic tick_run;
    logic alarm_hit;

    assign tick_run  = (state.mode == achms_pkg::MODE_CLOCK) && state.valid_flag;
    assign alarm_hit = state.armed_flag && (state.alarm_hours == state.cur_hours)
                       && (state.alarm_mins == state.cur_mins);

    always_comb
    begin
        state_next = state;
        case (item.action)
            achms_pkg::ACT_TICK:
            begin
                if (tick_run)
                begin
                    // alarm compare uses the time before the advance
                    if (alarm_hit)
                    begin
                        state_next.armed_flag = 1'b0;
                        state_next.sound_flag = 1'b1;
                    end
                    state_next.cur_secs = achms_pkg::bump6(state.cur_secs,
                                                           achms_pkg::SECS_PER_MIN);
                    if (state_next.cur_secs == 6'd0)
                    begin
                        state_next.cur_mins = achms_pkg::bump6(state.cur_mins,
                                                               achms_pkg::MINUTES_PER_HOUR);
                        if (state_next.cur_mins == 6'd0)
                        begin
                            state_next.cur_hours = achms_pkg::bump5(state.cur_hours,
                                                                    achms_pkg::HOURS_PER_DAY);
                        end
                    end
                end
            end
            achms_pkg::ACT_MODE:
            begin
                if (state.sound_flag)
                begin
                    state_next.sound_flag = 1'b0;
                end
                else
                begin
                    case (state.mode)
                        achms_pkg::MODE_CLOCK:
                        begin
                            state_next.edit_mins  = state.cur_mins;
                            state_next.edit_hours = state.cur_hours;
                            state_next.mode       = achms_pkg::MODE_SET_TIME;
                        end
                        achms_pkg::MODE_SET_TIME:
                        begin
                            state_next.cur_mins   = state.edit_mins;
                            state_next.cur_hours  = state.edit_hours;
                            state_next.cur_secs   = 6'd0;
                            state_next.valid_flag = 1'b1;
                            state_next.edit_mins  = 6'd0;
                            state_next.edit_hours = 5'd0;
                            state_next.mode       = achms_pkg::MODE_SET_ALARM;
                        end
                        achms_pkg::MODE_SET_ALARM:
                        begin
                            state_next.alarm_mins  = state.edit_mins;
                            state_next.alarm_hours = state.edit_hours;
                            state_next.armed_flag  = 1'b1;
                            state_next.mode        = achms_pkg::MODE_CLOCK;
                        end
                        default:
                        begin
                            state_next.mode = achms_pkg::MODE_CLOCK;
                        end
                    endcase
                end
            end
            achms_pkg::ACT_MINUTE:
            begin
                if (state.mode != achms_pkg::MODE_CLOCK)
                begin
                    state_next.edit_mins = achms_pkg::bump6(state.edit_mins,
                                                            achms_pkg::MINUTES_PER_HOUR);
                end
            end
            achms_pkg::ACT_HOUR:
            begin
                if (state.mode != achms_pkg::MODE_CLOCK)
                begin
                    state_next.edit_hours = achms_pkg::bump5(state.edit_hours,
                                                             achms_pkg::HOURS_PER_DAY);
                end
            end
            achms_pkg::ACT_LOAD:
            begin
                state_next.cur_hours  = achms_pkg::fit5(item.load_hours,
                                                        achms_pkg::HOURS_PER_DAY);
                state_next.cur_mins   = achms_pkg::fit6(item.load_mins,
                                                        achms_pkg::MINUTES_PER_HOUR);
                state_next.cur_secs   = achms_pkg::fit6(item.load_secs,
                                                        achms_pkg::SECS_PER_MIN);
                state_next.valid_flag = 1'b1;
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

    // display follows the updated state
    always_comb
    begin
        if (state_next.mode == achms_pkg::MODE_CLOCK)
        begin
            result.show_hours = state_next.cur_hours;
            result.show_mins  = state_next.cur_mins;
            result.show_secs  = state_next.cur_secs;
        end
        else
        begin
            result.show_hours = state_next.edit_hours;
            result.show_mins  = state_next.edit_mins;
            result.show_secs  = 6'd0;
        end
        result.show_mode    = state_next.mode;
        result.sound_active = state_next.sound_flag;
        result.alarm_armed  = state_next.armed_flag;
        result.time_valid   = state_next.valid_flag;
    end

endmodule

>>> rtl/alarm_clock_hms_top.sv
// Top level of the event-driven 24-hour alarm clock.
// A request is held in the request register, then passes through the state update into the response register.
// Throughput: one request per cycle while the response is not stalled, set by the
// combinational state update between the request register and the response register.
// A stalled response holds the response register; the request register takes one more.
// Reset (rst_n low, asynchronous): time 0:00:00, clock mode, flags clear, both stages empty.
`include "alarm_clock_hms_top_defines.svh"

module alarm_clock_hms_top (
    input  logic              clk,
    input  logic              rst_n,
    achms_req_if.sink         req,
    achms_rsp_if.source       rsp
);

    // request stage
    logic                s1_valid_reg;
    achms_pkg::item_t    item_reg;

    // clock state and response stage
    achms_pkg::state_t   state_reg;
    achms_pkg::state_t   state_next;
    logic                rsp_valid_reg;
    achms_pkg::result_t  result_reg;
    achms_pkg::result_t  result_next;

    logic                req_take;
    logic                advance;

    // the request stage moves on when the response register is empty or being drained
    assign advance  = s1_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;
    assign req_take = req.valid && req.ready;

    achms_step u_step (
        .item       (item_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            item_reg.action     <= achms_pkg::action_t'(req.action);
            item_reg.load_hours <= req.load_hours;
            item_reg.load_mins  <= req.load_mins;
            item_reg.load_secs  <= req.load_secs;
        end
    end

    // time, mode and alarm state commit with each request that moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{cur_secs: 6'd0, cur_mins: 6'd0, cur_hours: 5'd0,
                           valid_flag: 1'b0, mode: achms_pkg::MODE_CLOCK,
                           edit_mins: 6'd0, edit_hours: 5'd0,
                           alarm_mins: 6'd0, alarm_hours: 5'd0,
                           armed_flag: 1'b0, sound_flag: 1'b0};
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.show_hours   = result_reg.show_hours;
    assign rsp.show_mins    = result_reg.show_mins;
    assign rsp.show_secs    = result_reg.show_secs;
    assign rsp.show_mode    = result_reg.show_mode;
    assign rsp.sound_active = result_reg.sound_active;
    assign rsp.alarm_armed  = result_reg.alarm_armed;
    assign rsp.time_valid   = result_reg.time_valid;

    // state only changes when a request moves into the response register
    `ACHMS_ASSERT_NEXT(a_state_held, clk, rst_n, !advance, $stable(state_reg))
    // once valid, the time stays valid
    `ACHMS_ASSERT_NEXT(a_valid_sticky, clk, rst_n, state_reg.valid_flag, state_reg.valid_flag)
    // the alarm only starts ringing on a tick
    `ACHMS_ASSERT_NEXT(a_sound_on_tick, clk, rst_n,
                       !advance || (item_reg.action != achms_pkg::ACT_TICK),
                       !$rose(state_reg.sound_flag))
    // every request that moves on shows up as a response
    `ACHMS_ASSERT_NEXT(a_rsp_loaded, clk, rst_n, advance, rsp_valid_reg)

endmodule
